FILE: hdl/kbrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kbrt_pkg
// Shared types and codes for the keyed buffer reuse table.
// ----------------------------------------------------------------------------
package kbrt_pkg;

	localparam int OUTCOME_W = 3;
	localparam int OUT_IDX_W = 7;
	localparam int COPY_W    = 32;
	localparam int FE_W      = 8;
	localparam int FB_W      = 39;
	localparam int CNT_OUT_W = 32;

	localparam int ACT_COPY_BIT  = 0;
	localparam int ACT_SWEEP_BIT = 1;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_REUSED   = 3'd0,
		OUT_FRESH    = 3'd1,
		OUT_DISCARD  = 3'd2,
		OUT_COPY     = 3'd3,
		OUT_FULL     = 3'd4,
		OUT_SWEEP    = 3'd5
	} outcome_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SCAN = 1'b1
	} state_t;

	// scan token handed from cell to cell
	typedef struct packed {
		logic live;
		logic hit;
		logic held_valid;
	} tok_t;

	// write broadcast into the row
	typedef struct packed {
		logic en;
		logic append;
	} wr_t;

endpackage : kbrt_pkg
`default_nettype wire

FILE: hdl/kbrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kbrt_cell
// One table slot: key, size, valid and occupied marks, plus one token stage.
// ----------------------------------------------------------------------------
module kbrt_cell
	import kbrt_pkg::*;
#(
	parameter int KEY_BITS  = 48,
	parameter int SIZE_BITS = 32,
	parameter int IDX_W     = 7,
	parameter int CELL_IDX  = 0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_sweep,
	input  wire logic [KEY_BITS-1:0]  cmd_key,
	input  wire logic [KEY_BITS-1:0]  cmd_top,
	input  wire tok_t                 tok_i,
	input  wire logic [IDX_W-1:0]     idx_i,
	input  wire logic [SIZE_BITS-1:0] held_i,
	input  wire logic [FE_W-1:0]      fe_i,
	input  wire logic [FB_W-1:0]      fb_i,
	input  wire wr_t                  wr,
	input  wire logic [IDX_W-1:0]     wr_idx,
	input  wire logic [KEY_BITS-1:0]  wr_key,
	input  wire logic [SIZE_BITS-1:0] wr_size,
	output tok_t                      tok_o,
	output logic [IDX_W-1:0]          idx_o,
	output logic [SIZE_BITS-1:0]      held_o,
	output logic [FE_W-1:0]           fe_o,
	output logic [FB_W-1:0]           fb_o
);

	localparam int SEXT = (SIZE_BITS > FB_W) ? SIZE_BITS : FB_W;
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [KEY_BITS-1:0]  key_q;
	logic [SIZE_BITS-1:0] size_q;
	logic                 valid_q;
	logic                 occ_q;
	logic [SEXT-1:0]      size_ext;
	logic                 wr_me;
	logic                 freed;
	logic                 match;

	assign size_ext = SEXT'(size_q);
	assign wr_me    = wr.en && (wr_idx == MY_IDX);
	assign freed    = tok_i.live && cmd_sweep && occ_q && valid_q && (key_q < cmd_top);
	assign match    = tok_i.live && !cmd_sweep && !tok_i.hit && occ_q && (key_q == cmd_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			occ_q   <= 1'b0;
			tok_o   <= '0;
		end else begin
			tok_o <= '{live: tok_i.live,
				hit: tok_i.hit || match,
				held_valid: match ? valid_q : tok_i.held_valid};
			if (wr_me) begin
				valid_q <= 1'b1;
				if (wr.append) begin
					occ_q <= 1'b1;
				end
			end else if (freed) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_me) begin
			size_q <= wr_size;
			if (wr.append) begin
				key_q <= wr_key;
			end
		end
		idx_o  <= match ? MY_IDX : idx_i;
		held_o <= match ? size_q : held_i;
		fe_o   <= freed ? fe_i + FE_W'(1) : fe_i;
		fb_o   <= freed ? fb_i + size_ext[FB_W-1:0] : fb_i;
	end

endmodule : kbrt_cell
`default_nettype wire

FILE: hdl/keyed_buffer_reuse_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_buffer_reuse_table
// Keyed table of held buffer sizes with reuse decision and stack sweep.
// ----------------------------------------------------------------------------
// channel   handshake        fields
// command   start / busy     action, key_address, request_size, stack_top
// result    done (strobe)    outcome, entry_index, copy_bytes, freed_entries,
//                            freed_bytes, live_bytes, alloc_count, reuse_count
//
// Every command runs one scan from start to done: a scan token walks the
// row of cells one slot per cycle.
// busy is high from the cycle after start until the cycle done is shown.
// done is high for one cycle; the receiver cannot stall it.
// Reset clears valid and occupied marks and all totals at once.
// ----------------------------------------------------------------------------
module keyed_buffer_reuse_table
	import kbrt_pkg::*;
#(
	parameter int TABLE_DEPTH = 128,
	parameter int KEY_BITS    = 48,
	parameter int SIZE_BITS   = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [1:0]           action,
	input  wire logic [KEY_BITS-1:0]  key_address,
	input  wire logic [SIZE_BITS-1:0] request_size,
	input  wire logic [KEY_BITS-1:0]  stack_top,
	output logic                      done,
	output logic [OUTCOME_W-1:0]      outcome,
	output logic [OUT_IDX_W-1:0]      entry_index,
	output logic [COPY_W-1:0]         copy_bytes,
	output logic [FE_W-1:0]           freed_entries,
	output logic [FB_W-1:0]           freed_bytes,
	output logic [FB_W-1:0]           live_bytes,
	output logic [CNT_OUT_W-1:0]      alloc_count,
	output logic [CNT_OUT_W-1:0]      reuse_count
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int SEXT  = (SIZE_BITS > FB_W) ? SIZE_BITS : FB_W;
	localparam int CEXT  = (SIZE_BITS > COPY_W) ? SIZE_BITS : COPY_W;
	localparam int IEXT  = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

	state_t               state_q, state_d;
	logic                 launch_q;
	logic                 cmd_sweep_q;
	logic                 cmd_copy_q;
	logic [KEY_BITS-1:0]  cmd_key_q;
	logic [KEY_BITS-1:0]  cmd_top_q;
	logic [SIZE_BITS-1:0] cmd_req_q;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [FB_W-1:0]      live_q, live_d;
	logic [CNT_OUT_W-1:0] alloc_q, alloc_d;
	logic [CNT_OUT_W-1:0] reuse_q, reuse_d;
	logic                 done_d;
	logic [OUTCOME_W-1:0] outcome_d;
	logic [OUT_IDX_W-1:0] index_d;
	logic [COPY_W-1:0]    copy_d;
	logic [FE_W-1:0]      fe_d;
	logic [FB_W-1:0]      fb_d;

	tok_t                 tok_c  [0:TABLE_DEPTH];
	logic [IDX_W-1:0]     idx_c  [0:TABLE_DEPTH];
	logic [SIZE_BITS-1:0] held_c [0:TABLE_DEPTH];
	logic [FE_W-1:0]      fe_c   [0:TABLE_DEPTH];
	logic [FB_W-1:0]      fb_c   [0:TABLE_DEPTH];

	wr_t                  wr;
	logic [IDX_W-1:0]     wr_idx;

	tok_t                 tail;
	logic [IDX_W-1:0]     slot;
	logic                 hv;
	logic [SIZE_BITS-1:0] held;
	logic [SIZE_BITS:0]   req_dbl;
	logic                 reuse;
	logic [SIZE_BITS-1:0] min_sz;
	logic [SEXT-1:0]      held_x, req_x;
	logic [CEXT-1:0]      min_x;
	logic [IEXT-1:0]      slot_x;

	assign busy = (state_q != ST_IDLE);

	assign tok_c[0]  = '{live: launch_q, hit: 1'b0, held_valid: 1'b0};
	assign idx_c[0]  = '0;
	assign held_c[0] = '0;
	assign fe_c[0]   = '0;
	assign fb_c[0]   = '0;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		kbrt_cell #(
			.KEY_BITS  (KEY_BITS),
			.SIZE_BITS (SIZE_BITS),
			.IDX_W     (IDX_W),
			.CELL_IDX  (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd_sweep (cmd_sweep_q),
			.cmd_key   (cmd_key_q),
			.cmd_top   (cmd_top_q),
			.tok_i     (tok_c[g]),
			.idx_i     (idx_c[g]),
			.held_i    (held_c[g]),
			.fe_i      (fe_c[g]),
			.fb_i      (fb_c[g]),
			.wr        (wr),
			.wr_idx    (wr_idx),
			.wr_key    (cmd_key_q),
			.wr_size   (cmd_req_q),
			.tok_o     (tok_c[g+1]),
			.idx_o     (idx_c[g+1]),
			.held_o    (held_c[g+1]),
			.fe_o      (fe_c[g+1]),
			.fb_o      (fb_c[g+1])
		);
	end

	assign tail    = tok_c[TABLE_DEPTH];
	assign slot    = tail.hit ? idx_c[TABLE_DEPTH] : count_q[IDX_W-1:0];
	assign hv      = tail.hit && tail.held_valid;
	assign held    = held_c[TABLE_DEPTH];
	assign req_dbl = {cmd_req_q, 1'b0};
	assign reuse   = hv && (held > cmd_req_q)
		&& (({1'b0, held} < req_dbl) || cmd_copy_q);
	assign min_sz  = (held < cmd_req_q) ? held : cmd_req_q;
	assign held_x  = SEXT'(held);
	assign req_x   = SEXT'(cmd_req_q);
	assign min_x   = CEXT'(min_sz);
	assign slot_x  = IEXT'(slot);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		live_d    = live_q;
		alloc_d   = alloc_q;
		reuse_d   = reuse_q;
		done_d    = 1'b0;
		outcome_d = OUT_FULL;
		index_d   = '0;
		copy_d    = '0;
		fe_d      = '0;
		fb_d      = '0;
		wr        = '0;
		wr_idx    = slot;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (tail.live) begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
					if (cmd_sweep_q) begin
						outcome_d = OUT_SWEEP;
						fe_d      = fe_c[TABLE_DEPTH];
						fb_d      = fb_c[TABLE_DEPTH];
						live_d    = live_q - fb_c[TABLE_DEPTH];
					end else if (!tail.hit && (count_q == FULL_CNT)) begin
						outcome_d = OUT_FULL;
					end else if (reuse) begin
						outcome_d = OUT_REUSED;
						index_d   = slot_x[OUT_IDX_W-1:0];
						reuse_d   = reuse_q + CNT_OUT_W'(1);
					end else begin
						index_d   = slot_x[OUT_IDX_W-1:0];
						wr.en     = 1'b1;
						wr.append = !tail.hit;
						if (!tail.hit) begin
							count_d = count_q + CNT_W'(1);
						end
						alloc_d = alloc_q + CNT_OUT_W'(1);
						live_d  = live_q - (hv ? held_x[FB_W-1:0] : '0) + req_x[FB_W-1:0];
						if (!hv) begin
							outcome_d = OUT_FRESH;
						end else if (cmd_copy_q) begin
							outcome_d = OUT_COPY;
							copy_d    = min_x[COPY_W-1:0];
						end else begin
							outcome_d = OUT_DISCARD;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			launch_q <= 1'b0;
			count_q  <= '0;
			live_q   <= '0;
			alloc_q  <= '0;
			reuse_q  <= '0;
			done     <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= start && !busy;
			count_q  <= count_d;
			live_q   <= live_d;
			alloc_q  <= alloc_d;
			reuse_q  <= reuse_d;
			done     <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_sweep_q <= action[ACT_SWEEP_BIT];
			cmd_copy_q  <= action[ACT_COPY_BIT];
			cmd_key_q   <= key_address;
			cmd_top_q   <= stack_top;
			cmd_req_q   <= request_size;
		end
		if (done_d) begin
			outcome       <= outcome_d;
			entry_index   <= index_d;
			copy_bytes    <= copy_d;
			freed_entries <= fe_d;
			freed_bytes   <= fb_d;
			live_bytes    <= live_d;
			alloc_count   <= alloc_d;
			reuse_count   <= reuse_d;
		end
	end

endmodule : keyed_buffer_reuse_table
`default_nettype wire

FILE: verif/tb_keyed_buffer_reuse_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_buffer_reuse_table
// Self-checking bench for the keyed buffer reuse table. A directed opening
// exercises zero and full-scale sizes, the reuse thresholds, realloc copies,
// the spare sweep code and sweep boundaries. A random phase then grows a pool
// of stack keys until the table fills, mixing reuse, replacement and sweeps.
// Every reply is checked field by field against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb_keyed_buffer_reuse_table;
	import kbrt_pkg::*;

	localparam int DEPTH        = 128;
	localparam int KEY_W        = 48;
	localparam int SIZE_W       = 32;
	localparam int RANDOM_ITEMS = 1230;
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = DEPTH + 20;

	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_REALLOC = 2'd1;
	localparam logic [1:0] ACT_SWEEP   = 2'd2;
	localparam logic [1:0] ACT_SPARE   = 2'd3;

	localparam logic [KEY_W-1:0] K_LOW  = '0;
	localparam logic [KEY_W-1:0] K_HIGH = '1;
	localparam logic [KEY_W-1:0] K_MID  = 48'h7ffe_1234_5678;
	localparam logic [KEY_W-1:0] K_NEAR = 48'h0000_8000_0001;

	typedef struct packed {
		outcome_t               outcome;
		logic [OUT_IDX_W-1:0]   entry_index;
		logic [COPY_W-1:0]      copy_bytes;
		logic [FE_W-1:0]        freed_entries;
		logic [FB_W-1:0]        freed_bytes;
		logic [FB_W-1:0]        live_bytes;
		logic [CNT_OUT_W-1:0]   alloc_count;
		logic [CNT_OUT_W-1:0]   reuse_count;
	} reply_t;

	class reuse_table_tracker;
		logic [KEY_W-1:0]     slot_key [DEPTH];
		logic [SIZE_W-1:0]    slot_size [DEPTH];
		bit                   slot_live [DEPTH];
		int unsigned          used_slots = 0;
		logic [FB_W-1:0]      live_total = '0;
		logic [CNT_OUT_W-1:0] alloc_total = '0;
		logic [CNT_OUT_W-1:0] reuse_total = '0;
		reply_t               pending_replies [$];
		int unsigned          errors = 0;
		int unsigned          outcome_seen [6];

		function void take_request(input logic [1:0] act, input logic [KEY_W-1:0] key,
				input logic [SIZE_W-1:0] req, input logic [KEY_W-1:0] top);
			reply_t r;
			int unsigned i;
			int unsigned slot;
			logic [SIZE_W-1:0] held;
			r = '0;
			if (act[ACT_SWEEP_BIT]) begin
				r.outcome = OUT_SWEEP;
				for (i = 0; i < used_slots; i++) begin
					if (slot_live[i] && slot_key[i] < top) begin
						slot_live[i] = 1'b0;
						r.freed_entries = r.freed_entries + 1'b1;
						r.freed_bytes = r.freed_bytes + slot_size[i];
						live_total = live_total - slot_size[i];
					end
				end
			end else begin
				slot = used_slots;
				for (i = 0; i < used_slots; i++) begin
					if (slot_key[i] == key) begin
						slot = i;
						break;
					end
				end
				if (slot == used_slots && used_slots >= DEPTH) begin
					r.outcome = OUT_FULL;
				end else begin
					if (slot == used_slots) begin
						slot_key[slot] = key;
						slot_live[slot] = 1'b0;
						slot_size[slot] = '0;
						used_slots++;
					end
					held = slot_size[slot];
					r.entry_index = OUT_IDX_W'(slot);
					// reuse needs held > req and held < 2*req (33-bit compare), or a realloc
					if (slot_live[slot] && held > req &&
							({1'b0, held} < {req, 1'b0} || act[ACT_COPY_BIT])) begin
						r.outcome = OUT_REUSED;
						reuse_total = reuse_total + 1'b1;
					end else begin
						if (!slot_live[slot]) begin
							r.outcome = OUT_FRESH;
						end else begin
							live_total = live_total - held;
							if (act[ACT_COPY_BIT]) begin
								r.outcome = OUT_COPY;
								r.copy_bytes = (held < req) ? held : req;
							end else begin
								r.outcome = OUT_DISCARD;
							end
						end
						slot_size[slot] = req;
						slot_live[slot] = 1'b1;
						live_total = live_total + req;
						alloc_total = alloc_total + 1'b1;
					end
				end
			end
			r.live_bytes = live_total;
			r.alloc_count = alloc_total;
			r.reuse_count = reuse_total;
			pending_replies.push_back(r);
		endfunction

		function void compare_field(input string label, input logic [63:0] want_v,
				input logic [63:0] got_v);
			if (got_v !== want_v) begin
				$error("%s: expected %0d, got %0d", label, want_v, got_v);
				errors++;
			end
		endfunction

		function void check_reply(input reply_t got);
			reply_t want;
			if (pending_replies.size() == 0) begin
				$error("reply with no command pending: outcome %0d", got.outcome);
				errors++;
				return;
			end
			want = pending_replies.pop_front();
			outcome_seen[want.outcome]++;
			compare_field("outcome", want.outcome, got.outcome);
			compare_field("entry_index", want.entry_index, got.entry_index);
			compare_field("copy_bytes", want.copy_bytes, got.copy_bytes);
			compare_field("freed_entries", want.freed_entries, got.freed_entries);
			compare_field("freed_bytes", want.freed_bytes, got.freed_bytes);
			compare_field("live_bytes", want.live_bytes, got.live_bytes);
			compare_field("alloc_count", want.alloc_count, got.alloc_count);
			compare_field("reuse_count", want.reuse_count, got.reuse_count);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [1:0]             action = ACT_ALLOC;
	logic [KEY_W-1:0]       key_address = '0;
	logic [SIZE_W-1:0]      request_size = '0;
	logic [KEY_W-1:0]       stack_top = '0;
	logic                   done;
	logic [OUTCOME_W-1:0]   outcome;
	logic [OUT_IDX_W-1:0]   entry_index;
	logic [COPY_W-1:0]      copy_bytes;
	logic [FE_W-1:0]        freed_entries;
	logic [FB_W-1:0]        freed_bytes;
	logic [FB_W-1:0]        live_bytes;
	logic [CNT_OUT_W-1:0]   alloc_count;
	logic [CNT_OUT_W-1:0]   reuse_count;

	reuse_table_tracker     tracker = new;
	int unsigned            issued = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	keyed_buffer_reuse_table #(
		.TABLE_DEPTH(DEPTH),
		.KEY_BITS(KEY_W),
		.SIZE_BITS(SIZE_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.key_address(key_address),
		.request_size(request_size),
		.stack_top(stack_top),
		.done(done),
		.outcome(outcome),
		.entry_index(entry_index),
		.copy_bytes(copy_bytes),
		.freed_entries(freed_entries),
		.freed_bytes(freed_bytes),
		.live_bytes(live_bytes),
		.alloc_count(alloc_count),
		.reuse_count(reuse_count)
	);

	// one command transfer, then at times an idle gap (none inside back-to-back stretches)
	task automatic issue(input logic [1:0] act, input logic [KEY_W-1:0] key,
			input logic [SIZE_W-1:0] req, input logic [KEY_W-1:0] top);
		int unsigned roll;
		int unsigned gap;
		action <= act;
		key_address <= key;
		request_size <= req;
		stack_top <= top;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		tracker.take_request(act, key, req, top);
		issued++;
		roll = $urandom_range(0, 99);
		gap = 0;
		if ((issued / 64) % 4 != 1) begin
			if (roll >= 88)
				gap = $urandom_range(20, 200);
			else if (roll >= 55)
				gap = $urandom_range(1, 4);
		end
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin : take_reply
		reply_t got;
		if (done === 1'b1) begin
			got.outcome = outcome_t'(outcome);
			got.entry_index = entry_index;
			got.copy_bytes = copy_bytes;
			got.freed_entries = freed_entries;
			got.freed_bytes = freed_bytes;
			got.live_bytes = live_bytes;
			got.alloc_count = alloc_count;
			got.reuse_count = reuse_count;
			tracker.check_reply(got);
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		int unsigned n;
		int unsigned pick;
		int unsigned roll;
		logic [1:0] act;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] top;
		logic [SIZE_W-1:0] req;
		logic [SIZE_W-1:0] hint;
		logic [KEY_W-1:0] pool_key [$];
		logic [SIZE_W-1:0] pool_size [$];

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(ACT_SWEEP,   K_LOW,  32'd0,         K_HIGH);     // empty table
		issue(ACT_ALLOC,   K_LOW,  32'd0,         K_LOW);      // fresh, zero size
		issue(ACT_ALLOC,   K_LOW,  32'd0,         K_LOW);      // zero held is never reused
		issue(ACT_REALLOC, K_LOW,  32'd0,         K_LOW);
		issue(ACT_ALLOC,   K_MID,  32'd100,       K_LOW);
		issue(ACT_REALLOC, K_MID,  32'd0,         K_LOW);      // zero request, realloc reuses
		issue(ACT_ALLOC,   K_MID,  32'd0,         K_LOW);      // zero request, alloc replaces
		issue(ACT_ALLOC,   K_MID,  32'd100,       K_LOW);
		issue(ACT_ALLOC,   K_MID,  32'd50,        K_LOW);      // held == 2*req
		issue(ACT_ALLOC,   K_MID,  32'd26,        K_LOW);      // just under 2*req
		issue(ACT_REALLOC, K_MID,  32'd80,        K_LOW);      // grow: copy held
		issue(ACT_REALLOC, K_MID,  32'd80,        K_LOW);      // equal: copy all
		issue(ACT_ALLOC,   K_HIGH, 32'hffff_ffff, K_LOW);
		issue(ACT_ALLOC,   K_HIGH, 32'h8000_0000, K_LOW);
		issue(ACT_ALLOC,   K_HIGH, 32'h7fff_ffff, K_LOW);
		issue(ACT_REALLOC, K_HIGH, 32'd1,         K_LOW);
		issue(ACT_REALLOC, K_NEAR, 32'd500,       K_LOW);      // new key on realloc
		issue(ACT_SWEEP,   K_LOW,  32'd0,         K_MID);      // key equal to top survives
		issue(ACT_SPARE,   K_LOW,  32'd0,         K_MID + 1);
		issue(ACT_ALLOC,   K_MID,  32'd10,        K_LOW);      // swept entry comes back fresh
		issue(ACT_SWEEP,   K_LOW,  32'd0,         K_LOW);
		issue(ACT_SPARE,   K_HIGH, 32'hffff_ffff, K_HIGH);

		pool_key = '{K_LOW, K_MID, K_HIGH, K_NEAR};
		pool_size = '{32'd0, 32'd10, 32'h7fff_ffff, 32'd500};

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			roll = $urandom_range(0, 99);
			key = KEY_W'({$urandom, $urandom});
			top = KEY_W'({$urandom, $urandom});
			req = $urandom;
			if (roll < 12) begin
				act = ($urandom_range(0, 3) == 0) ? ACT_SPARE : ACT_SWEEP;
				case ($urandom_range(0, 19))
				0: begin
					top = '0;
				end
				1: begin
					top = '1;
				end
				2, 3, 4, 5, 6: ;
				default: begin
					top = pool_key[$urandom_range(0, pool_key.size() - 1)] +
						KEY_W'($urandom_range(0, 1));
				end
				endcase
			end else begin
				act = $urandom_range(0, 1) ? ACT_REALLOC : ACT_ALLOC;
				if ($urandom_range(0, 99) < (pool_key.size() < DEPTH ? 20 : 5)) begin
					pick = pool_key.size();
					if (pick < DEPTH) begin
						pool_key.push_back(key);
						pool_size.push_back('0);
					end
				end else begin
					pick = $urandom_range(0, pool_key.size() - 1);
					key = pool_key[pick];
				end
				hint = (pick < pool_size.size()) ? pool_size[pick] : '0;
				case ($urandom_range(0, 11))
				0: ;
				1: begin
					req = '0;
				end
				2: begin
					req = '1;
				end
				3: begin
					req = hint;
				end
				4: begin
					req = hint - SIZE_W'($urandom_range(0, 3));
				end
				5: begin
					req = (hint >> 1) + SIZE_W'($urandom_range(0, 2));
				end
				6: begin
					req = hint + SIZE_W'($urandom_range(1, 16));
				end
				default: begin
					req = SIZE_W'($urandom_range(1, 65536));
				end
				endcase
				if (pick < pool_size.size())
					pool_size[pick] = req;
			end
			issue(act, key, req, top);
		end

		start <= 1'b0;
		while (tracker.pending_replies.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d commands; %0d of %0d table slots in use at the end",
			issued, tracker.used_slots, DEPTH);
		$display("Replies: reused %0d, fresh %0d, discard %0d, copy %0d, full %0d, sweep %0d",
			tracker.outcome_seen[OUT_REUSED], tracker.outcome_seen[OUT_FRESH],
			tracker.outcome_seen[OUT_DISCARD], tracker.outcome_seen[OUT_COPY],
			tracker.outcome_seen[OUT_FULL], tracker.outcome_seen[OUT_SWEEP]);
		if (tracker.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: keyed_buffer_reuse_table.f
hdl/kbrt_pkg.sv
hdl/kbrt_cell.sv
hdl/keyed_buffer_reuse_table.sv
verif/tb_keyed_buffer_reuse_table.sv
